// ----- design/trp_pkg.sv -----
// Shared constants, types and the report merge function of the record/playback block.
package trp_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int TIME_BITS = 48;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int HEADER_BITS = 8;
	localparam int REPORT_BITS = 56;
	localparam int ENTRY_BITS = TIME_BITS + REPORT_BITS;

	localparam logic [HEADER_BITS-1:0] STORED_HEADER = 8'd85;
	localparam logic [7:0] STICK_NEUTRAL = 8'd128;
	localparam logic [7:0] HAT_NEUTRAL = 8'd8;

	typedef enum logic [1:0] {
		MODE_BLOCK = 2'd0,
		MODE_INPUT = 2'd1,
		MODE_MACRO = 2'd2,
		MODE_PASS  = 2'd3
	} mode_t;

	typedef enum logic {
		REQ_PLAYBACK = 1'b0,
		REQ_RECORD   = 1'b1
	} req_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic srch_init;
		logic rd_mid;
		logic cmp;
		logic rd_lo;
		logic do_rec;
		logic do_pass;
		logic do_fetch;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_record;
		logic direct;
		logic more;
	} status_t;

	// Buttons are ORed; neutral stick bytes and a neutral hat of the priority
	// report are filled from the other report.
	function automatic logic [REPORT_BITS-1:0] merge_reports(
		input logic [REPORT_BITS-1:0] pri,
		input logic [REPORT_BITS-1:0] oth
	);
		logic [REPORT_BITS-1:0] r;
		r = pri | {{(REPORT_BITS-16){1'b0}}, oth[15:0]};
		for (int k = 2; k < 6; k++) begin
			if (r[8*k +: 8] == STICK_NEUTRAL) begin
				r[8*k +: 8] = oth[8*k +: 8];
			end
		end
		if (r[55:48] == HAT_NEUTRAL) begin
			r[55:48] = oth[55:48];
		end
		return r;
	endfunction

endpackage

// ----- design/trp_in_if.sv -----
// Request channel interface: valid/ready handshake with the request payload.
interface trp_in_if import trp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [TIME_BITS-1:0]   time_req;
	logic [HEADER_BITS-1:0] header;
	logic [REPORT_BITS-1:0] report;

	modport source (output valid, output req_type, output time_req, output header,
		output report, input ready);
	modport sink (input valid, input req_type, input time_req, input header,
		input report, output ready);
endinterface

// ----- design/trp_out_if.sv -----
// Result channel interface: valid/ready handshake with the result payload.
interface trp_out_if import trp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [HEADER_BITS-1:0] out_header;
	logic [REPORT_BITS-1:0] out_report;
	logic                   appended;
	logic                   store_full;

	modport source (output valid, output out_header, output out_report,
		output appended, output store_full, input ready);
	modport sink (input valid, input out_header, input out_report,
		input appended, input store_full, output ready);
endinterface

// ----- design/trp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module trp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- design/trp_ctrl.sv -----
// Controller state machine sequencing record, pass-through and search steps.
module trp_ctrl import trp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t sts,
	output cmd_t    cmd
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_REC    = 7'b0000100,
		S_PASS   = 7'b0001000,
		S_CHK    = 7'b0010000,
		S_CMP    = 7'b0100000,
		S_FETCH  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load = cmd.do_rec || cmd.do_pass || cmd.do_fetch;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_record) begin
					state_d = S_REC;
				end else if (sts.direct) begin
					state_d = S_PASS;
				end else begin
					cmd.srch_init = 1'b1;
					state_d = S_CHK;
				end
			end
			S_REC: begin
				if (out_free) begin
					cmd.do_rec = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PASS: begin
				if (out_free) begin
					cmd.do_pass = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CHK: begin
				if (sts.more) begin
					cmd.rd_mid = 1'b1;
					state_d = S_CMP;
				end else begin
					cmd.rd_lo = 1'b1;
					state_d = S_FETCH;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_CHK;
			end
			S_FETCH: begin
				if (out_free) begin
					cmd.do_fetch = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- design/trp_dp.sv -----
// Datapath: request latch, entry store, search bounds, merge and result register.
module trp_dp import trp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode_we,
	input  logic [1:0]             mode_wdata,
	input  logic                   req_type,
	input  logic [TIME_BITS-1:0]   time_req,
	input  logic [HEADER_BITS-1:0] header,
	input  logic [REPORT_BITS-1:0] report,
	input  cmd_t                   cmd,
	output status_t                sts,
	output logic [HEADER_BITS-1:0] out_header,
	output logic [REPORT_BITS-1:0] out_report,
	output logic                   appended,
	output logic                   store_full
);
	mode_t                  mode_q;
	logic [CNT_W-1:0]       count_q;
	logic                   req_type_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [HEADER_BITS-1:0] header_q;
	logic [REPORT_BITS-1:0] report_q;
	logic [REPORT_BITS-1:0] last_report_q;
	logic [CNT_W-1:0]       lo_q, hi_q;
	logic [ADDR_W-1:0]      mid_q;
	logic [CNT_W-1:0]       span;
	logic [CNT_W-1:0]       mid_next;
	logic                   dup;
	logic                   full;
	logic                   wr_en;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ENTRY_BITS-1:0]  rd_data;
	logic [TIME_BITS-1:0]   rd_time;
	logic [REPORT_BITS-1:0] rd_report;

	assign span = hi_q - lo_q;
	assign mid_next = lo_q + (span >> 1);
	assign dup = (count_q != '0) && (last_report_q == report_q);
	assign full = (count_q == CNT_W'(STORE_DEPTH));
	assign wr_en = cmd.do_rec && !dup && !full;
	assign rd_en = cmd.rd_mid || cmd.rd_lo;
	assign rd_addr = cmd.rd_mid ? mid_next[ADDR_W-1:0] : lo_q[ADDR_W-1:0];
	assign rd_time = rd_data[TIME_BITS-1:0];
	assign rd_report = rd_data[TIME_BITS +: REPORT_BITS];

	assign sts.is_record = (req_type_q == REQ_RECORD);
	assign sts.direct = (count_q == '0) || (mode_q == MODE_PASS);
	assign sts.more = (span > CNT_W'(1));

	trp_ram #(
		.W(ENTRY_BITS),
		.D(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({report_q, time_q}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BLOCK;
			count_q <= '0;
		end else begin
			if (mode_we) begin
				mode_q <= mode_t'(mode_wdata);
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req_type;
			time_q <= time_req;
			header_q <= header;
			report_q <= report;
		end
		if (wr_en) begin
			last_report_q <= report_q;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.cmp) begin
			if (rd_time > time_q) begin
				hi_q <= {{(CNT_W-ADDR_W){1'b0}}, mid_q};
			end else begin
				lo_q <= {{(CNT_W-ADDR_W){1'b0}}, mid_q};
			end
		end
		if (cmd.rd_mid) begin
			mid_q <= mid_next[ADDR_W-1:0];
		end

		if (cmd.do_rec) begin
			out_header <= '0;
			out_report <= '0;
			appended <= !dup && !full;
			store_full <= !dup && full;
		end else if (cmd.do_pass) begin
			out_header <= header_q;
			out_report <= report_q;
			appended <= 1'b0;
			store_full <= 1'b0;
		end else if (cmd.do_fetch) begin
			appended <= 1'b0;
			store_full <= 1'b0;
			case (mode_q)
				MODE_INPUT: begin
					out_header <= header_q;
					out_report <= merge_reports(report_q, rd_report);
				end
				MODE_MACRO: begin
					out_header <= STORED_HEADER;
					out_report <= merge_reports(rd_report, report_q);
				end
				default: begin
					out_header <= STORED_HEADER;
					out_report <= rd_report;
				end
			endcase
		end
	end
endmodule

// ----- design/timed_report_record_playback.sv -----
// Top level of the timed report record and playback store.
//
//   Channel   Dir  Payload                                         Handshake
//   req       in   req_type, time_req, header, report              valid/ready
//   res       out  out_header, out_report, appended, store_full    valid/ready
//   mode cfg  in   merge_mode_wdata                                merge_mode_we
//
// One transaction is worked on at a time. A record transaction goes from the
// accepting idle state through decode to the record state, where its result
// is loaded; a playback transaction on an empty store, or in pass-through
// mode, goes through decode to the pass state. A playback search repeats a
// halving step while more than one entry lies between the bounds, then loads
// the result from the lower-bound entry. Each halving step needs one read of
// the store's single read port and one compare of the registered read data.
// Reset clears the entry count, the merge mode and the control state at once;
// the entry store itself needs no clearing, since only written entries are
// ever read. A new request is taken while an earlier result still waits in the
// output register; a finished item only waits if that register is still full.
module timed_report_record_playback import trp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       merge_mode_we,
	input  logic [1:0] merge_mode_wdata,
	trp_in_if.sink     req,
	trp_out_if.source  res
);
	cmd_t    cmd;
	status_t sts;

	// The controller owns the handshakes and the state sequence; it sees the
	// datapath only through the status bundle.
	trp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the request, the entry store, the search bounds and
	// the result register that drives the result channel payload.
	trp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (merge_mode_we),
		.mode_wdata (merge_mode_wdata),
		.req_type   (req.req_type),
		.time_req   (req.time_req),
		.header     (req.header),
		.report     (req.report),
		.cmd        (cmd),
		.sts        (sts),
		.out_header (res.out_header),
		.out_report (res.out_report),
		.appended   (res.appended),
		.store_full (res.store_full)
	);
endmodule

// ----- design/trp_chk.sv -----
// Port-level checker for the record/playback block, bound to the top level.
module trp_chk import trp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [HEADER_BITS-1:0] out_header,
	input logic [REPORT_BITS-1:0] out_report,
	input logic                   appended,
	input logic                   store_full
);
	// One request at a time: after a transaction is taken, the next waits.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken on consecutive cycles");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(appended && store_full))
		else $error("appended and store_full both set");

	// Record results carry an all-zero header and report.
	a_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (appended || store_full) |-> out_header == '0 && out_report == '0)
		else $error("record result with nonzero payload");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_header)
		&& $stable(out_report) && $stable(appended) && $stable(store_full))
		else $error("stalled result changed");
endmodule

bind timed_report_record_playback trp_chk u_trp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_header (res.out_header),
	.out_report (res.out_report),
	.appended   (res.appended),
	.store_full (res.store_full)
);
